FILE: rtl/ajas_pkg.sv
// ----------------------------------------------------------------------------
// ajas_pkg
// Shared widths, constants and control types for the joint angle smoother.
// ----------------------------------------------------------------------------
package ajas_pkg;

  // Field and arithmetic widths
  localparam int RAW_W      = 15;  // raw joint angle, signed
  localparam int ALPHA_W    = 16;  // Q1.15 weight register
  localparam int THR_W      = 15;  // step threshold register
  localparam int CFG_IDX_W  = 2;   // configuration register index
  localparam int CALC_W     = 17;  // target, previous value and step difference
  localparam int PROD_W     = 34;  // multiplier product
  localparam int DIV_NUM_W  = 31;  // step times alpha span
  localparam int DIV_Q_W    = 16;  // interpolation quotient
  localparam int DIV_R_W    = 15;  // divider remainder
  localparam int ALPHA_FRAC = 15;  // fraction bits of a weight

  // Constants
  localparam int                      ANGLE_LIMIT = 23040;
  localparam logic [ALPHA_W-1:0]      ALPHA_ONE   = 16'h8000;
  localparam logic signed [PROD_W-1:0] ROUND_HALF = 34'sd16384;

  // Register reset values
  localparam logic [ALPHA_W-1:0] ALPHA_MIN_RST = 16'd3277;
  localparam logic [ALPHA_W-1:0] ALPHA_MAX_RST = 16'd26214;
  localparam logic [THR_W-1:0]   STEP_THR_RST  = 15'd640;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ALPHA_MIN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ALPHA_MAX = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_THR  = 2'd2;

  // Item commands
  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_CALIB  = 1'b1;

  // Controller to datapath
  typedef struct packed {
    logic load;        // capture the incoming item
    logic calib;       // copy offsets, clear filter memory
    logic target;      // form target, difference and step for current joint
    logic mul_step;    // product of step and alpha span
    logic div_start;   // start the interpolation divide
    logic set_alpha;   // form interpolated alpha
    logic mul_filter;  // product of alpha and difference
    logic commit;      // write joint result, advance joint
    logic out_load;    // load output register from held outputs
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic primed;      // filter has seen a sample
    logic big_step;    // step above threshold, maximum weight applies
    logic div_busy;    // divider still iterating
    logic last_joint;  // current joint is the last one
  } dp_status_t;

endpackage

FILE: rtl/ajas_divider.sv
// ----------------------------------------------------------------------------
// ajas_divider
// Restoring divider, one quotient bit per cycle, for alpha interpolation.
// The numerator is known to give a quotient below 2**16.
// ----------------------------------------------------------------------------
module ajas_divider (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic [ajas_pkg::DIV_NUM_W-1:0]  num,
  input  logic [ajas_pkg::THR_W-1:0]      den,
  output logic [ajas_pkg::DIV_Q_W-1:0]    quot,
  output logic                            rem_nz,
  output logic                            busy
);

  localparam int QW    = ajas_pkg::DIV_Q_W;
  localparam int RW    = ajas_pkg::DIV_R_W;
  localparam int CNT_W = $clog2(QW);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(QW - 1);

  logic [RW-1:0]    rem_q;
  logic [QW-1:0]    quot_q;
  logic [CNT_W-1:0] cnt;
  logic [RW:0]      shifted;
  logic [RW:0]      den_x;
  logic [RW:0]      trial;
  logic             fits;

  // One trial subtraction
  assign shifted = {rem_q, quot_q[QW-1]};
  assign den_x   = {1'b0, den};
  assign trial   = shifted - den_x;
  assign fits    = (shifted >= den_x);

  // Iterate
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + 1'b1;
      if (cnt == CNT_LAST) begin
        busy <= 1'b0;
      end
    end
  end

  // Remainder and quotient shift
  always_ff @(posedge clk) begin
    if (start) begin
      rem_q  <= num[ajas_pkg::DIV_NUM_W-1:QW];
      quot_q <= num[QW-1:0];
    end else if (busy) begin
      rem_q  <= fits ? trial[RW-1:0] : shifted[RW-1:0];
      quot_q <= {quot_q[QW-2:0], fits};
    end
  end

  assign quot   = quot_q;
  assign rem_nz = (rem_q != '0);

endmodule

FILE: rtl/ajas_datapath.sv
// ----------------------------------------------------------------------------
// ajas_datapath
// Joint state, configuration registers, shared multiplier and divider,
// and the output register of the joint angle smoother.
// ----------------------------------------------------------------------------
module ajas_datapath #(
  parameter int JOINT_COUNT = 4,
  parameter int ANGLE_WIDTH = 16,
  parameter int IN_W        = 64,
  parameter int OUT_W       = 64
) (
  input  logic                             clk,
  input  logic                             rst,
  input  ajas_pkg::dp_cmd_t                cmd,
  output ajas_pkg::dp_status_t             status,
  input  logic [IN_W-1:0]                  in_data,
  input  logic [JOINT_COUNT-1:0]           in_found,
  input  logic                             cfg_we,
  input  logic [ajas_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ajas_pkg::ALPHA_W-1:0]     cfg_data,
  output logic [OUT_W-1:0]                 out_data
);

  localparam int JW = (JOINT_COUNT > 1) ? $clog2(JOINT_COUNT) : 1;
  localparam int CW = ajas_pkg::CALC_W;
  localparam int PW = ajas_pkg::PROD_W;
  localparam int RW = ajas_pkg::RAW_W;
  localparam int AL = ajas_pkg::ALPHA_W;
  localparam int TW = ajas_pkg::THR_W;
  localparam int QW = ajas_pkg::DIV_Q_W;
  localparam longint WMAX  = (longint'(1) << (ANGLE_WIDTH - 1)) - 1;
  localparam longint LIM_L = (WMAX < ajas_pkg::ANGLE_LIMIT) ? WMAX : ajas_pkg::ANGLE_LIMIT;
  localparam logic signed [PW-1:0] LIM_HI = PW'(LIM_L);
  localparam logic signed [PW-1:0] LIM_LO = -LIM_HI;
  localparam logic [JW-1:0] JOINT_LAST = JW'(JOINT_COUNT - 1);

  // Clamp to the angle range
  function automatic logic signed [CW-1:0] clamp_angle(input logic signed [PW-1:0] v);
    logic signed [PW-1:0] c;
    c = v;
    if (v > LIM_HI) begin
      c = LIM_HI;
    end else if (v < LIM_LO) begin
      c = LIM_LO;
    end
    return CW'(c);
  endfunction

  // Configuration registers
  logic [AL-1:0] alpha_min;
  logic [AL-1:0] alpha_max;
  logic [TW-1:0] step_thr;

  // Captured item
  logic signed [RW-1:0] raw_q [JOINT_COUNT];
  logic [JOINT_COUNT-1:0] found_q;

  // Joint state
  logic signed [RW-1:0]          zero_offset [JOINT_COUNT];
  logic signed [RW-1:0]          last_raw    [JOINT_COUNT];
  logic signed [ANGLE_WIDTH-1:0] held_output [JOINT_COUNT];
  logic signed [ANGLE_WIDTH-1:0] filter_mem  [JOINT_COUNT];
  logic [JOINT_COUNT-1:0]        last_found;
  logic                          primed;
  logic [JW-1:0]                 jidx;

  // Per joint work registers
  logic signed [CW-1:0] tgt_q;
  logic signed [CW-1:0] prev_q;
  logic signed [CW-1:0] diff_q;
  logic [CW-2:0]        step_q;
  logic [AL-1:0]        alpha_q;
  logic signed [PW-1:0] prod_q;

  // Combinational signals
  logic [AL-1:0]          amin_c;
  logic [AL-1:0]          amax_c;
  logic [TW-1:0]          thr_c;
  logic signed [CW-1:0]   delta;
  logic                   delta_neg;
  logic [AL-1:0]          delta_mag;
  logic signed [CW-1:0]   tgt_c;
  logic signed [CW-1:0]   prev_c;
  logic signed [CW-1:0]   diff_c;
  logic signed [CW-1:0]   diff_neg;
  logic [CW-2:0]          step_c;
  logic signed [CW-1:0]   mul_a;
  logic signed [CW-1:0]   mul_b;
  logic signed [PW-1:0]   prod_c;
  logic [QW-1:0]          quot;
  logic                   rem_nz;
  logic                   div_busy;
  logic signed [QW+1:0]   q_ext;
  logic signed [QW+1:0]   q_floor;
  logic signed [QW+1:0]   alpha_sum;
  logic signed [PW-1:0]   filt_acc;
  logic signed [PW-1:0]   filt_sum;
  logic signed [CW-1:0]   result_c;
  logic [OUT_W-1:0]       out_next;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      alpha_min <= ajas_pkg::ALPHA_MIN_RST;
      alpha_max <= ajas_pkg::ALPHA_MAX_RST;
      step_thr  <= ajas_pkg::STEP_THR_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        ajas_pkg::REG_ALPHA_MIN: alpha_min <= cfg_data;
        ajas_pkg::REG_ALPHA_MAX: alpha_max <= cfg_data;
        ajas_pkg::REG_STEP_THR:  step_thr  <= cfg_data[TW-1:0];
        default: ;
      endcase
    end
  end

  // Limit weights to one, threshold to at least one
  assign amin_c    = (alpha_min > ajas_pkg::ALPHA_ONE) ? ajas_pkg::ALPHA_ONE : alpha_min;
  assign amax_c    = (alpha_max > ajas_pkg::ALPHA_ONE) ? ajas_pkg::ALPHA_ONE : alpha_max;
  assign thr_c     = (step_thr == '0) ? TW'(1) : step_thr;
  assign delta     = signed'({1'b0, amax_c}) - signed'({1'b0, amin_c});
  assign delta_neg = delta[CW-1];
  assign delta_mag = delta_neg ? AL'(-delta) : delta[AL-1:0];

  // Capture the item
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      for (int i = 0; i < JOINT_COUNT; i++) begin
        raw_q[i] <= in_data[i*RW +: RW];
      end
      found_q <= in_found;
    end
  end

  // Target, difference and step of the current joint
  assign tgt_c    = found_q[jidx] ? clamp_angle(PW'(signed'({raw_q[jidx][RW-1], raw_q[jidx]}) -
                                                 signed'({zero_offset[jidx][RW-1],
                                                          zero_offset[jidx]})))
                                  : CW'(held_output[jidx]);
  assign prev_c   = CW'(filter_mem[jidx]);
  assign diff_c   = tgt_c - prev_c;
  assign diff_neg = -diff_c;
  assign step_c   = diff_c[CW-1] ? diff_neg[CW-2:0] : diff_c[CW-2:0];

  always_ff @(posedge clk) begin
    if (cmd.target) begin
      tgt_q   <= tgt_c;
      prev_q  <= prev_c;
      diff_q  <= diff_c;
      step_q  <= step_c;
      alpha_q <= amax_c;
    end else if (cmd.set_alpha) begin
      alpha_q <= alpha_sum[AL-1:0];
    end
  end

  // Shared multiplier
  assign mul_a  = cmd.mul_filter ? signed'({1'b0, alpha_q}) : signed'({1'b0, step_q});
  assign mul_b  = cmd.mul_filter ? diff_q : signed'({1'b0, delta_mag});
  assign prod_c = mul_a * mul_b;

  always_ff @(posedge clk) begin
    if (cmd.mul_step || cmd.mul_filter) begin
      prod_q <= prod_c;
    end
  end

  // Interpolation divide
  ajas_divider u_div (
    .clk    (clk),
    .rst    (rst),
    .start  (cmd.div_start),
    .num    (prod_q[ajas_pkg::DIV_NUM_W-1:0]),
    .den    (thr_c),
    .quot   (quot),
    .rem_nz (rem_nz),
    .busy   (div_busy)
  );

  // Floor of the signed quotient, then alpha
  assign q_ext     = signed'({2'b00, quot});
  assign q_floor   = delta_neg ? (-q_ext - signed'({{(QW+1){1'b0}}, rem_nz})) : q_ext;
  assign alpha_sum = signed'({2'b00, amin_c}) + q_floor;

  // Filter step, rounded to nearest
  assign filt_acc = prod_q + ajas_pkg::ROUND_HALF;
  assign filt_sum = PW'(prev_q) + (filt_acc >>> ajas_pkg::ALPHA_FRAC);
  assign result_c = primed ? clamp_angle(filt_sum) : tgt_q;

  // Joint state update
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < JOINT_COUNT; i++) begin
        zero_offset[i] <= '0;
        last_raw[i]    <= '0;
        held_output[i] <= '0;
        filter_mem[i]  <= '0;
      end
      last_found <= '0;
      primed     <= 1'b0;
      jidx       <= '0;
    end else if (cmd.calib) begin
      for (int i = 0; i < JOINT_COUNT; i++) begin
        if (last_found[i] && i != 1) begin
          zero_offset[i] <= last_raw[i];
        end
        filter_mem[i] <= '0;
      end
    end else if (cmd.commit) begin
      filter_mem[jidx]  <= ANGLE_WIDTH'(result_c);
      held_output[jidx] <= ANGLE_WIDTH'(result_c);
      last_raw[jidx]    <= raw_q[jidx];
      last_found[jidx]  <= found_q[jidx];
      if (jidx == JOINT_LAST) begin
        jidx   <= '0;
        primed <= 1'b1;
      end else begin
        jidx <= jidx + 1'b1;
      end
    end
  end

  // Output register
  always_comb begin
    out_next = '0;
    for (int i = 0; i < JOINT_COUNT; i++) begin
      out_next[i*ANGLE_WIDTH +: ANGLE_WIDTH] = held_output[i];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data <= out_next;
    end
  end

  assign status.primed     = primed;
  assign status.big_step   = ({1'b0, step_c} > {2'b00, thr_c});
  assign status.div_busy   = div_busy;
  assign status.last_joint = (jidx == JOINT_LAST);

endmodule

FILE: rtl/ajas_ctrl.sv
// ----------------------------------------------------------------------------
// ajas_ctrl
// Sequencer of the joint angle smoother: walks the joints one by one
// through target, alpha interpolation and filter, then hands off the item.
// ----------------------------------------------------------------------------
module ajas_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic                  in_cmd,
  output logic                  in_ready,
  output logic                  out_valid,
  input  logic                  out_ready,
  output ajas_pkg::dp_cmd_t     cmd,
  input  ajas_pkg::dp_status_t  status
);

  typedef enum logic [9:0] {
    ST_IDLE     = 10'b00_0000_0001,
    ST_CALIB    = 10'b00_0000_0010,
    ST_TARGET   = 10'b00_0000_0100,
    ST_MUL_STEP = 10'b00_0000_1000,
    ST_DIV_GO   = 10'b00_0001_0000,
    ST_DIV_WAIT = 10'b00_0010_0000,
    ST_ALPHA    = 10'b00_0100_0000,
    ST_MUL_FILT = 10'b00_1000_0000,
    ST_COMMIT   = 10'b01_0000_0000,
    ST_OUTPUT   = 10'b10_0000_0000
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_free;

  assign in_ready = (state == ST_IDLE);
  assign out_free = !out_valid || out_ready;

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = (in_cmd == ajas_pkg::CMD_CALIB) ? ST_CALIB : ST_TARGET;
        end
      end
      ST_CALIB: begin
        cmd.calib  = 1'b1;
        state_next = ST_IDLE;
      end
      ST_TARGET: begin
        cmd.target = 1'b1;
        if (!status.primed) begin
          state_next = ST_COMMIT;
        end else if (status.big_step) begin
          state_next = ST_MUL_FILT;
        end else begin
          state_next = ST_MUL_STEP;
        end
      end
      ST_MUL_STEP: begin
        cmd.mul_step = 1'b1;
        state_next   = ST_DIV_GO;
      end
      ST_DIV_GO: begin
        cmd.div_start = 1'b1;
        state_next    = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (!status.div_busy) begin
          state_next = ST_ALPHA;
        end
      end
      ST_ALPHA: begin
        cmd.set_alpha = 1'b1;
        state_next    = ST_MUL_FILT;
      end
      ST_MUL_FILT: begin
        cmd.mul_filter = 1'b1;
        state_next     = ST_COMMIT;
      end
      ST_COMMIT: begin
        cmd.commit = 1'b1;
        state_next = status.last_joint ? ST_OUTPUT : ST_TARGET;
      end
      ST_OUTPUT: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Hold the result until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

FILE: rtl/adaptive_joint_angle_smoother.sv
// ----------------------------------------------------------------------------
// adaptive_joint_angle_smoother
// Each sample walks the joints in turn: before the filter is primed through
// target and commit; above the step threshold through target, filter multiply
// and commit; else through target, step multiply, alpha divide, alpha set,
// filter multiply and commit. Throughput: one item at a time, calibrates too.
// Reset clears the joint state and loads the default weights and threshold.
// ----------------------------------------------------------------------------
module adaptive_joint_angle_smoother #(
  parameter int JOINT_COUNT = 4,
  parameter int ANGLE_WIDTH = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  // Input items
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // raw_angle_0 .. raw_angle_N, 15 bits each, zero padded to bytes
  input  logic [((JOINT_COUNT * ajas_pkg::RAW_W + 7) / 8) * 8 - 1:0] s_tdata,
  // cmd, found_0 .. found_N
  input  logic [JOINT_COUNT:0]            s_tuser,
  // Result items
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // smooth_angle_0 .. smooth_angle_N, ANGLE_WIDTH bits each, zero padded
  output logic [((JOINT_COUNT * ANGLE_WIDTH + 7) / 8) * 8 - 1:0] m_tdata,
  // Configuration writes
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [ajas_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ajas_pkg::ALPHA_W-1:0]    cfg_data
);

  localparam int IN_W  = ((JOINT_COUNT * ajas_pkg::RAW_W + 7) / 8) * 8;
  localparam int OUT_W = ((JOINT_COUNT * ANGLE_WIDTH + 7) / 8) * 8;

  ajas_pkg::dp_cmd_t    cmd;
  ajas_pkg::dp_status_t status;

  assign cfg_ready = 1'b1;

  // Sequencer
  ajas_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_cmd    (s_tuser[0]),
    .in_ready  (s_tready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .cmd       (cmd),
    .status    (status)
  );

  // Arithmetic and joint state
  ajas_datapath #(
    .JOINT_COUNT (JOINT_COUNT),
    .ANGLE_WIDTH (ANGLE_WIDTH),
    .IN_W        (IN_W),
    .OUT_W       (OUT_W)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .in_data   (s_tdata),
    .in_found  (s_tuser[JOINT_COUNT:1]),
    .cfg_we    (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_data  (m_tdata)
  );

endmodule
